// ===== src/apjq_pkg.sv =====
// ----------------------------------------------------------------------------
// apjq_pkg
// Shared constants, codes and types of the two-class job queue with aging.
// ----------------------------------------------------------------------------
package apjq_pkg;

  localparam int QUEUE_DEPTH  = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int TIME_BITS    = 32;
  localparam int THRESH_BITS  = 32;
  localparam int STATUS_BITS  = 2;
  localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
  localparam int INDEX_BITS   = $clog2(QUEUE_DEPTH);

  localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(5000);

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  localparam logic CLASS_FREE    = 1'b0;
  localparam logic CLASS_PREMIUM = 1'b1;

  localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] payload;
    logic                    cls;
    logic [TIME_BITS-1:0]    created;
  } slot_t;

  typedef struct packed {
    logic load;     // take the incoming job
    logic shift;    // take the neighbour's job
    logic capture;  // register the selection flags
  } cell_ctl_t;

  typedef struct packed {
    logic starved;
    logic premium;
  } cell_flags_t;

endpackage

// ===== src/apjq_cell.sv =====
// ----------------------------------------------------------------------------
// apjq_cell
// One queue slot: holds a job, takes the new job or its neighbour's job, and
// registers whether the job is starved or premium.
// ----------------------------------------------------------------------------
module apjq_cell (
  input  logic                                clk,
  input  apjq_pkg::cell_ctl_t                 ctl,
  input  apjq_pkg::slot_t                     new_job,
  input  apjq_pkg::slot_t                     neighbour,
  input  logic [apjq_pkg::TIME_BITS-1:0]      now_time,
  input  logic [apjq_pkg::THRESH_BITS-1:0]    threshold,
  output apjq_pkg::slot_t                     job,
  output apjq_pkg::cell_flags_t               flags
);

  logic [apjq_pkg::TIME_BITS-1:0] wait_time;

  // Wrapping difference, so a time counter roll-over is harmless
  assign wait_time = now_time - job.created;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      job <= new_job;
    end else if (ctl.shift) begin
      job <= neighbour;
    end
    if (ctl.capture) begin
      flags.starved <= (job.cls == apjq_pkg::CLASS_FREE) && (wait_time >= threshold);
      flags.premium <= (job.cls == apjq_pkg::CLASS_PREMIUM);
    end
  end

endmodule

// ===== src/aging_priority_job_queue_core.sv =====
// ----------------------------------------------------------------------------
// aging_priority_job_queue_core
// Two-class job queue with aging, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): action 0 appends a job at the tail,
//   action 1 removes one job: the oldest free job that has waited at least
//   starve_threshold, else the oldest premium job, else the head.
//   Output channel (out_valid / out_stall): one result per input transfer,
//   held in an output register until the receiver takes it.
//   Configuration channel (cfg_valid / cfg_ready): writes starve_threshold;
//   cfg_ready is always high.
// Timing:
//   An enqueue, and a dequeue on an empty queue, finish in the transfer
//   cycle: the result is valid the next cycle. In a dequeue of a queue
//   with jobs, each cell registers its starved / premium flags in the
//   transfer cycle, and the pick, the read-out and the gap closing follow in
//   the next. Enqueues: 1 item per cycle unless stalled; none taken in a pick.
// Reset (rst, synchronous): queue empty, no result pending, threshold 5000.
// While the receiver stalls a pending result, no further item is taken.
// ----------------------------------------------------------------------------
module aging_priority_job_queue_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 action,
  input  logic [apjq_pkg::PAYLOAD_BITS-1:0]    job_payload,
  input  logic                                 job_class,
  input  logic [apjq_pkg::TIME_BITS-1:0]       job_created,
  input  logic [apjq_pkg::TIME_BITS-1:0]       now_time,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [apjq_pkg::STATUS_BITS-1:0]     status,
  output logic [apjq_pkg::PAYLOAD_BITS-1:0]    out_payload,
  output logic                                 out_class,
  output logic [apjq_pkg::TIME_BITS-1:0]       out_created,
  output logic                                 was_starved,
  output logic                                 now_empty,
  output logic [apjq_pkg::COUNT_BITS-1:0]      entry_count,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [apjq_pkg::THRESH_BITS-1:0]     cfg_data
);

  typedef enum logic {IDLE, PICK} state_t;

  state_t                               state;
  logic [apjq_pkg::COUNT_BITS-1:0]      count;
  logic [apjq_pkg::THRESH_BITS-1:0]     threshold;

  logic                                 out_free;
  logic                                 accept;
  logic                                 do_pick;
  apjq_pkg::slot_t                      new_job;
  apjq_pkg::slot_t                      jobs   [apjq_pkg::QUEUE_DEPTH];
  apjq_pkg::slot_t                      nbrs   [apjq_pkg::QUEUE_DEPTH];
  apjq_pkg::cell_flags_t                flags  [apjq_pkg::QUEUE_DEPTH];
  apjq_pkg::cell_ctl_t                  ctls   [apjq_pkg::QUEUE_DEPTH];
  logic [apjq_pkg::QUEUE_DEPTH-1:0]     starved_vec;
  logic [apjq_pkg::QUEUE_DEPTH-1:0]     premium_vec;
  logic [apjq_pkg::INDEX_BITS-1:0]      starved_idx;
  logic [apjq_pkg::INDEX_BITS-1:0]      premium_idx;
  logic [apjq_pkg::INDEX_BITS-1:0]      pick;
  logic                                 pick_starved;
  apjq_pkg::slot_t                      picked;

  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state == PICK) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign do_pick   = (state == PICK) && out_free;
  assign cfg_ready = 1'b1;

  assign new_job.payload = job_payload;
  assign new_job.cls     = job_class;
  assign new_job.created = job_created;

  // Row of slot cells; on a pick, each one behind the picked slot hands its job to the cell in front
  for (genvar i = 0; i < apjq_pkg::QUEUE_DEPTH; i++) begin : g_cell
    if (i == apjq_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign nbrs[i] = jobs[i];
    end else begin : g_mid
      assign nbrs[i] = jobs[i+1];
    end

    assign ctls[i].load    = accept && (action == apjq_pkg::ACT_ENQUEUE)
                             && (count == apjq_pkg::COUNT_BITS'(i));
    assign ctls[i].shift   = do_pick && (apjq_pkg::INDEX_BITS'(i) >= pick);
    assign ctls[i].capture = accept;

    assign starved_vec[i] = flags[i].starved && (apjq_pkg::COUNT_BITS'(i) < count);
    assign premium_vec[i] = flags[i].premium && (apjq_pkg::COUNT_BITS'(i) < count);

    apjq_cell u_cell (
      .clk       (clk),
      .ctl       (ctls[i]),
      .new_job   (new_job),
      .neighbour (nbrs[i]),
      .now_time  (now_time),
      .threshold (threshold),
      .job       (jobs[i]),
      .flags     (flags[i])
    );
  end

  // Lowest set index wins: scan from the tail down
  always_comb begin
    starved_idx = '0;
    premium_idx = '0;
    for (int k = apjq_pkg::QUEUE_DEPTH - 1; k >= 0; k--) begin
      if (starved_vec[k]) begin
        starved_idx = k[apjq_pkg::INDEX_BITS-1:0];
      end
      if (premium_vec[k]) begin
        premium_idx = k[apjq_pkg::INDEX_BITS-1:0];
      end
    end
  end

  always_comb begin
    pick_starved = 1'b0;
    priority if (|starved_vec) begin
      pick         = starved_idx;
      pick_starved = 1'b1;
    end else if (|premium_vec) begin
      pick = premium_idx;
    end else begin
      pick = '0;
    end
  end

  assign picked = jobs[pick];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      count     <= '0;
      threshold <= apjq_pkg::THRESH_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        threshold <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            out_payload <= '0;
            out_class   <= 1'b0;
            out_created <= '0;
            was_starved <= 1'b0;
            if (action == apjq_pkg::ACT_ENQUEUE) begin
              out_valid <= 1'b1;
              now_empty <= 1'b0;
              if (count == apjq_pkg::COUNT_BITS'(apjq_pkg::QUEUE_DEPTH)) begin
                status      <= apjq_pkg::STATUS_FULL;
                entry_count <= count;
              end else begin
                status      <= apjq_pkg::STATUS_DONE;
                count       <= count + 1'b1;
                entry_count <= count + 1'b1;
              end
            end else if (count == '0) begin
              out_valid   <= 1'b1;
              status      <= apjq_pkg::STATUS_EMPTY;
              now_empty   <= 1'b1;
              entry_count <= count;
            end else begin
              state <= PICK;
            end
          end
        end
        PICK: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= apjq_pkg::STATUS_DONE;
            out_payload <= picked.payload;
            out_class   <= picked.cls;
            out_created <= picked.created;
            was_starved <= pick_starved;
            now_empty   <= (count == apjq_pkg::COUNT_BITS'(1));
            entry_count <= count - 1'b1;
            count       <= count - 1'b1;
            state       <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== src/apjq_checker.sv =====
// ----------------------------------------------------------------------------
// apjq_checker
// Port-level checks of the job queue core, bound to the top level.
// ----------------------------------------------------------------------------
module apjq_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [apjq_pkg::STATUS_BITS-1:0]     status,
  input logic [apjq_pkg::PAYLOAD_BITS-1:0]    out_payload,
  input logic                                 out_class,
  input logic [apjq_pkg::TIME_BITS-1:0]       out_created,
  input logic                                 was_starved,
  input logic                                 now_empty,
  input logic [apjq_pkg::COUNT_BITS-1:0]      entry_count
);

  // A pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Empty flag agrees with the count, which stays within the queue depth
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (now_empty == (entry_count == '0))
                  && (entry_count <= apjq_pkg::COUNT_BITS'(apjq_pkg::QUEUE_DEPTH)))
    else $error("empty flag or count inconsistent");

  // Only a completed dequeue carries job data
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != apjq_pkg::STATUS_DONE)
      |-> (out_payload == '0) && !out_class && (out_created == '0) && !was_starved)
    else $error("job fields set on a rejected step");

  // A starvation pick is always a free job
  a_starved_free: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_starved
      |-> (out_class == apjq_pkg::CLASS_FREE) && (status == apjq_pkg::STATUS_DONE))
    else $error("starvation pick of a premium job");

endmodule

bind aging_priority_job_queue_core apjq_checker u_apjq_checker (.*);
